// File: rtl/assert_macros.svh
// Assertion macros used by the byte sequencer of the note event encoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds whenever the antecedent holds, outside reset.
`define MNEE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that an expression holds on every clock edge outside reset.
`define MNEE_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

`endif

// File: rtl/mnee_pkg.sv
// Package with the types and constants of the note event encoder.
package mnee_pkg;

    // Fixed field widths and queue depth.
    localparam int unsigned TIME_W      = 32;
    localparam int unsigned DIV_W       = 15;
    localparam int unsigned COUNT_OUT_W = 24;
    localparam int unsigned VLQ_BITS    = 28;
    localparam int unsigned QUEUE_DEPTH = 2;

    // Register reset value and encoding constants.
    localparam logic [DIV_W-1:0]    DIVISIONS_RESET = 15'd96;
    localparam logic [VLQ_BITS-1:0] MASK_GRP3  = 28'hfe00000;
    localparam logic [VLQ_BITS-1:0] MASK_GRP2  = 28'hfffc000;
    localparam logic [VLQ_BITS-1:0] MASK_GRP1  = 28'hfffff80;
    localparam logic [7:0]          STATUS_ON  = 8'h90;
    localparam logic [7:0]          STATUS_OFF = 8'h80;
    localparam logic [15:0]         VOLUME_ONE = 16'd32768;

    // Kind of the last status byte sent.
    typedef enum logic [1:0] {
        KIND_OFF  = 2'd0,
        KIND_ON   = 2'd1,
        KIND_NONE = 2'd2
    } kind_t;

    // One note event on the input side.
    typedef struct packed {
        logic [31:0] event_time;
        logic        note_on;
        logic [6:0]  pitch;
        logic [15:0] volume;
    } event_t;

    // One encoded byte on the result side.
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        last_of_event;
        logic        delta_error;
        logic [23:0] notes_on_count;
    } result_t;

    // Classified event handed from the front end to the byte sequencer.
    typedef struct packed {
        logic                   err;
        logic [VLQ_BITS-1:0]    ticks;
        logic [1:0]             top_grp;
        logic                   send_status;
        logic                   note_on;
        logic [6:0]             pitch;
        logic [6:0]             velocity;
        logic [COUNT_OUT_W-1:0] count;
    } cmd_t;

endpackage

// File: rtl/midi_note_event_encoder.sv
// Top level of the MIDI note event encoder: front end, queue and byte sequencer.
// An accepted event goes through stage 0, stage 1 and the queue into the output register.
// Front end: stage 0 holds an event until the previous one has left stage 1 and updated the state.
// Result side: one byte per cycle while popped, from the output register; 3 to 7 bytes per event, 1 on error.
// Reset: asynchronous, active low; clears the queue and output, divisions returns to 96,
// previous time and note-on count to zero, and the next event always sends a status byte.
module midi_note_event_encoder
    import mnee_pkg::*;
#(
    parameter int TIME_FRAC_BITS = 16,
    parameter int COUNT_WIDTH    = 24
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [DIV_W-1:0] cfg_wdata,
    input  logic             push,
    output logic             full,
    input  event_t           event_data,
    output logic             empty,
    input  logic             pop,
    output result_t          result_data
);

    logic cmd_push;
    logic cmd_full;
    cmd_t cmd_in;
    logic cmd_valid;
    logic cmd_pop;
    cmd_t cmd_out;

    // Front end: delta scaling and classification.
    mnee_front #(
        .TIME_FRAC_BITS(TIME_FRAC_BITS),
        .COUNT_WIDTH   (COUNT_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .push      (push),
        .full      (full),
        .event_data(event_data),
        .cmd_push  (cmd_push),
        .cmd_full  (cmd_full),
        .cmd       (cmd_in)
    );

    // Queue between the two halves.
    mnee_queue u_queue (
        .clk  (clk),
        .rst_n(rst_n),
        .push (cmd_push),
        .full (cmd_full),
        .wdata(cmd_in),
        .pop  (cmd_pop),
        .valid(cmd_valid),
        .rdata(cmd_out)
    );

    // Byte sequencer and output register.
    mnee_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd_out),
        .cmd_pop    (cmd_pop),
        .empty      (empty),
        .pop        (pop),
        .result_data(result_data)
    );

endmodule

// File: rtl/mnee_front.sv
// Front end: accepts note events, scales the delta time and classifies each event.
module mnee_front
    import mnee_pkg::*;
#(
    parameter int TIME_FRAC_BITS = 16,
    parameter int COUNT_WIDTH    = 24
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [DIV_W-1:0] cfg_wdata,
    input  logic             push,
    output logic             full,
    input  event_t           event_data,
    output logic             cmd_push,
    input  logic             cmd_full,
    output cmd_t             cmd
);

    localparam int PROD_W = TIME_W + DIV_W;
    localparam logic [PROD_W:0] HALF = {{PROD_W{1'b0}}, 1'b1} << (TIME_FRAC_BITS - 1);

    logic [DIV_W-1:0]       div_reg;
    logic                   s0_v_reg;
    event_t                 s0_reg;
    logic                   s1_v_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic                   neg_reg;
    logic [TIME_W-1:0]      time1_reg;
    logic                   on_reg;
    logic [6:0]             pitch_reg;
    logic [6:0]             vel_reg;
    logic [TIME_W-1:0]      prev_time_reg;
    kind_t                  prev_kind_reg;
    logic [COUNT_WIDTH-1:0] count_reg;

    logic                   accept;
    logic                   s0_go;
    logic                   s1_go;
    logic                   neg;
    logic [TIME_W-1:0]      mag;
    logic [PROD_W-1:0]      prod;
    logic [15:0]            vol_sat;
    logic [22:0]            vel_prod;
    logic [PROD_W:0]        ticks_all;
    logic                   err;
    logic [VLQ_BITS-1:0]    ticks;
    logic [1:0]             top_grp;
    kind_t                  kind;
    logic [COUNT_WIDTH-1:0] count_inc;

    // Handshake: stage 0 computes only once the previous event has updated the state.
    assign s1_go  = s1_v_reg && !cmd_full;
    assign s0_go  = s0_v_reg && !s1_v_reg;
    assign full   = s0_v_reg && !s0_go;
    assign accept = push && !full;

    // Stage 0: magnitude of the time difference times divisions, and velocity.
    always_comb
    begin
        neg      = s0_reg.event_time < prev_time_reg;
        mag      = neg ? (prev_time_reg - s0_reg.event_time)
                       : (s0_reg.event_time - prev_time_reg);
        prod     = PROD_W'(mag) * PROD_W'(div_reg);
        vol_sat  = (s0_reg.volume > VOLUME_ONE) ? VOLUME_ONE : s0_reg.volume;
        vel_prod = {vol_sat, 7'b0} - {7'b0, vol_sat};
    end

    // Stage 1: rounding, range check, byte count of the delta and running status.
    always_comb
    begin
        ticks_all = ({1'b0, prod_reg} + HALF) >> TIME_FRAC_BITS;
        err       = (neg_reg && (ticks_all != '0)) || (|ticks_all[PROD_W:VLQ_BITS]);
        ticks     = ticks_all[VLQ_BITS-1:0];
        if ((ticks & MASK_GRP3) != '0)
        begin
            top_grp = 2'd3;
        end
        else if ((ticks & MASK_GRP2) != '0)
        begin
            top_grp = 2'd2;
        end
        else if ((ticks & MASK_GRP1) != '0)
        begin
            top_grp = 2'd1;
        end
        else
        begin
            top_grp = 2'd0;
        end
        kind      = on_reg ? KIND_ON : KIND_OFF;
        count_inc = (on_reg && (count_reg != {COUNT_WIDTH{1'b1}}))
                  ? count_reg + COUNT_WIDTH'(1) : count_reg;
    end

    // Classified event toward the queue.
    always_comb
    begin
        cmd.err         = err;
        cmd.ticks       = ticks;
        cmd.top_grp     = top_grp;
        cmd.send_status = (kind != prev_kind_reg);
        cmd.note_on     = on_reg;
        cmd.pitch       = pitch_reg;
        cmd.velocity    = vel_reg;
        cmd.count       = err ? COUNT_OUT_W'(count_reg) : COUNT_OUT_W'(count_inc);
    end
    assign cmd_push = s1_v_reg;

    // Control state, divisions register and encoder state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_reg       <= DIVISIONS_RESET;
            s0_v_reg      <= 1'b0;
            s1_v_reg      <= 1'b0;
            prev_time_reg <= '0;
            prev_kind_reg <= KIND_NONE;
            count_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                div_reg <= cfg_wdata;
            end
            if (accept)
            begin
                s0_v_reg <= 1'b1;
            end
            else if (s0_go)
            begin
                s0_v_reg <= 1'b0;
            end
            if (s0_go)
            begin
                s1_v_reg <= 1'b1;
            end
            else if (s1_go)
            begin
                s1_v_reg <= 1'b0;
            end
            if (s1_go && !err)
            begin
                prev_time_reg <= time1_reg;
                prev_kind_reg <= kind;
                count_reg     <= count_inc;
            end
        end
    end

    // Payload registers of both stages.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s0_reg <= event_data;
        end
        if (s0_go)
        begin
            prod_reg  <= prod;
            neg_reg   <= neg;
            time1_reg <= s0_reg.event_time;
            on_reg    <= s0_reg.note_on;
            pitch_reg <= s0_reg.pitch;
            vel_reg   <= vel_prod[21:15];
        end
    end

endmodule

// File: rtl/mnee_queue.sv
// Short queue of classified events between the front end and the byte sequencer.
module mnee_queue
    import mnee_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    output logic full,
    input  cmd_t wdata,
    input  logic pop,
    output logic valid,
    output cmd_t rdata
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    cmd_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    // A transaction on each side.
    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign valid   = (count_reg != '0);
    assign do_push = push && !full;
    assign do_pop  = pop && valid;
    assign rdata   = mem_reg[rd_ptr_reg];

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// File: rtl/mnee_back.sv
// Byte sequencer: turns each classified event into its track event bytes.
`include "assert_macros.svh"
module mnee_back
    import mnee_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cmd_valid,
    input  cmd_t    cmd,
    output logic    cmd_pop,
    output logic    empty,
    input  logic    pop,
    output result_t result_data
);

    typedef enum logic [1:0] {
        PH_DELTA,
        PH_STATUS,
        PH_PITCH,
        PH_VEL
    } phase_t;

    phase_t  phase_reg;
    phase_t  phase_next;
    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic    out_v_reg;
    result_t out_reg;

    logic       load;
    logic       done;
    logic [1:0] grp;
    logic [6:0] grp_bits;
    result_t    res;

    // The output register takes a new byte when empty or when its byte is popped.
    assign load    = cmd_valid && (!out_v_reg || pop);
    assign cmd_pop = load && done;
    assign empty   = !out_v_reg;
    assign result_data = out_reg;

    // Seven-bit group of the delta for the current byte, most significant first.
    always_comb
    begin
        grp = cmd.top_grp - idx_reg;
        case (grp)
            2'd3:    grp_bits = cmd.ticks[27:21];
            2'd2:    grp_bits = cmd.ticks[20:14];
            2'd1:    grp_bits = cmd.ticks[13:7];
            default: grp_bits = cmd.ticks[6:0];
        endcase
    end

    // Byte selection and next phase.
    always_comb
    begin
        res.data_byte      = 8'h00;
        res.last_of_event  = 1'b0;
        res.delta_error    = 1'b0;
        res.notes_on_count = cmd.count;
        done       = 1'b0;
        phase_next = phase_reg;
        idx_next   = idx_reg;
        case (phase_reg)
            PH_DELTA:
            begin
                if (cmd.err)
                begin
                    res.last_of_event = 1'b1;
                    res.delta_error   = 1'b1;
                    done              = 1'b1;
                    idx_next          = 2'd0;
                end
                else
                begin
                    res.data_byte = {(grp != 2'd0), grp_bits};
                    if (grp == 2'd0)
                    begin
                        phase_next = cmd.send_status ? PH_STATUS : PH_PITCH;
                        idx_next   = 2'd0;
                    end
                    else
                    begin
                        idx_next = idx_reg + 2'd1;
                    end
                end
            end
            PH_STATUS:
            begin
                res.data_byte = cmd.note_on ? STATUS_ON : STATUS_OFF;
                phase_next    = PH_PITCH;
            end
            PH_PITCH:
            begin
                res.data_byte = {1'b0, cmd.pitch};
                phase_next    = PH_VEL;
            end
            PH_VEL:
            begin
                res.data_byte     = {1'b0, cmd.velocity};
                res.last_of_event = 1'b1;
                done              = 1'b1;
                phase_next        = PH_DELTA;
                idx_next          = 2'd0;
            end
            default:
            begin
                phase_next = PH_DELTA;
                idx_next   = 2'd0;
            end
        endcase
    end

    // Sequencer state, output valid and output byte register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_DELTA;
            idx_reg   <= 2'd0;
            out_v_reg <= 1'b0;
            out_reg   <= '0;
        end
        else
        begin
            if (load)
            begin
                phase_reg <= phase_next;
                idx_reg   <= idx_next;
                out_v_reg <= 1'b1;
                out_reg   <= res;
            end
            else if (pop)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    // An error result is always the only and last byte of its event.
    `MNEE_ASSERT_IMPL(a_err_is_last, clk, rst_n, out_v_reg && out_reg.delta_error, out_reg.last_of_event, "error result without last flag")
    // Past the delta bytes, the event being sent stays at the head of the queue.
    `MNEE_ASSERT_IMPL(a_head_held, clk, rst_n, phase_reg != PH_DELTA, cmd_valid && (idx_reg == 2'd0), "event left the queue mid sequence")
    // The delta byte index never runs past the top group of the event.
    `MNEE_ASSERT_ALWAYS(a_idx_bound, clk, rst_n, !cmd_valid || (idx_reg <= cmd.top_grp), "delta byte index past top group")

endmodule

// File: dv/tb_midi_note_event_encoder.sv
// Self-checking testbench for the MIDI note event encoder: directed table, then random events.
module tb_midi_note_event_encoder;
    import mnee_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TIME_FRAC     = 16;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int DIRECTED_ROWS = 17;
    localparam int PHASES        = 5;
    localparam int PHASE_ITEMS   = 54;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 20;

    // One row of the directed table; typed rows carry their expected bytes, first byte on top.
    typedef struct {
        bit          write_div;
        logic [14:0] div_value;
        event_t      ev;
        bit          typed;
        int          typed_len;
        logic [55:0] typed_bytes;
        logic        typed_err;
        logic [23:0] typed_count;
    } directed_row_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_we = 1'b0;
    logic [DIV_W-1:0] cfg_wdata = '0;
    logic             push = 1'b0;
    logic             full;
    event_t           event_data = '0;
    logic             empty;
    logic             pop = 1'b0;
    result_t          result_data;

    // Encoder state as the predictor sees it.
    logic [14:0] div_setting = DIVISIONS_RESET;
    logic [31:0] last_time   = '0;
    kind_t       last_kind   = KIND_NONE;
    logic [23:0] note_count  = '0;

    result_t     expected_bytes [$];
    result_t     typed_results [$];
    int unsigned fail_count      = 0;
    int unsigned events_accepted = 0;
    int unsigned rejected_deltas = 0;
    int unsigned bytes_checked   = 0;
    int unsigned div_writes      = 0;
    int unsigned cycle_count     = 0;
    bit          gaps_on         = 1'b1;

    midi_note_event_encoder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .push       (push),
        .full       (full),
        .event_data (event_data),
        .empty      (empty),
        .pop        (pop),
        .result_data(result_data)
    );

    // 12 ns clock.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    // Encodes one note event into its track bytes and advances the encoder state.
    function automatic void encode_event(input event_t ev, output result_t bytes_out [$]);
        logic        neg;
        logic [31:0] mag;
        logic [63:0] ticks;
        logic [27:0] delta;
        logic [7:0]  seq [$];
        logic [15:0] vol;
        logic [23:0] vel;
        kind_t       kind;

        bytes_out.delete();
        neg   = ev.event_time < last_time;
        mag   = neg ? last_time - ev.event_time : ev.event_time - last_time;
        ticks = (64'(mag) * 64'(div_setting) + (64'd1 << (TIME_FRAC - 1))) >> TIME_FRAC;

        // A backward delta that does not round to zero, or one past 28 bits, is rejected.
        if ((neg && ticks != 0) || ticks >= 64'h1000_0000)
        begin
            bytes_out.push_back('{8'h00, 1'b1, 1'b1, note_count});
            return;
        end

        // Big-endian variable-length delta, seven bits per byte.
        delta = ticks[27:0];
        if (delta[27:21] != 0)
            seq.push_back({1'b1, delta[27:21]});
        if (delta[27:14] != 0)
            seq.push_back({1'b1, delta[20:14]});
        if (delta[27:7] != 0)
            seq.push_back({1'b1, delta[13:7]});
        seq.push_back({1'b0, delta[6:0]});

        // Running status: a status byte only when the kind changes.
        kind = ev.note_on ? KIND_ON : KIND_OFF;
        if (kind != last_kind)
            seq.push_back(ev.note_on ? STATUS_ON : STATUS_OFF);

        // Volume above one clips, so velocity tops out at 127.
        vol = (ev.volume > VOLUME_ONE) ? VOLUME_ONE : ev.volume;
        vel = (24'(vol) * 24'd127) >> 15;
        seq.push_back({1'b0, ev.pitch});
        seq.push_back({1'b0, vel[6:0]});

        last_time = ev.event_time;
        last_kind = kind;
        if (ev.note_on && note_count != '1)
            note_count++;

        foreach (seq[i])
            bytes_out.push_back('{seq[i], i == seq.size() - 1, 1'b0, note_count});
    endfunction

    // Offers one event until it is taken, then records what it must produce.
    task automatic offer_event(input event_t ev);
        result_t predicted [$];

        push       <= 1'b1;
        event_data <= ev;
        @(posedge clk);
        while (full)
            @(posedge clk);

        encode_event(ev, predicted);
        if (typed_results.size() != 0)
        begin
            predicted = typed_results;
            typed_results.delete();
        end
        if (predicted[0].delta_error)
            rejected_deltas++;
        foreach (predicted[i])
            expected_bytes.push_back(predicted[i]);
        events_accepted++;

        while (gaps_on && $urandom_range(0, 99) < 22)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Writes the divisions register once every pending byte has come out.
    task automatic set_divisions(input logic [14:0] value);
        push <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we      <= 1'b0;
        div_setting = value;
        div_writes++;
    endtask

    // Result side: random pop stalls, two long hold-offs, byte checks.
    initial
    begin
        result_t     want;
        int unsigned hold_left;

        hold_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $display("%0t: byte with no transaction pending, actual %h",
                             $time, result_data);
                    fail_count++;
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (result_data.data_byte !== want.data_byte)
                    begin
                        $display("%0t: data_byte expected %h actual %h",
                                 $time, want.data_byte, result_data.data_byte);
                        fail_count++;
                    end
                    if (result_data.last_of_event !== want.last_of_event)
                    begin
                        $display("%0t: last_of_event expected %b actual %b",
                                 $time, want.last_of_event, result_data.last_of_event);
                        fail_count++;
                    end
                    if (result_data.delta_error !== want.delta_error)
                    begin
                        $display("%0t: delta_error expected %b actual %b",
                                 $time, want.delta_error, result_data.delta_error);
                        fail_count++;
                    end
                    if (result_data.notes_on_count !== want.notes_on_count)
                    begin
                        $display("%0t: notes_on_count expected %0d actual %0d",
                                 $time, want.notes_on_count, result_data.notes_on_count);
                        fail_count++;
                    end
                    bytes_checked++;
                    // Long hold-offs so that the encoder backs up and stalls its input.
                    if (bytes_checked == 300 || bytes_checked == 900)
                        hold_left = HOLD_CYCLES;
                end
            end

            if (hold_left != 0)
            begin
                pop <= 1'b0;
                hold_left--;
            end
            else if (!(bytes_checked >= 500 && bytes_checked < 800)
                     && $urandom_range(0, 99) < 22)
                pop <= 1'b0;
            else
                pop <= 1'b1;
        end
    end

    // Stimulus: reset, directed table, then random phases over several divisions settings.
    initial
    begin
        directed_row_t rows [DIRECTED_ROWS];
        logic [14:0]   phase_div [PHASES];
        event_t        ev;
        int unsigned   pick;
        int unsigned   item_no;

        // After reset, running status, clipped volume and a rejected backward delta.
        rows[0]  = '{1'b0, 15'd0, '{32'h0000_0000, 1'b1, 7'd60, 16'd32768}, 1'b1, 4,
                     {8'h00, 8'h90, 8'h3c, 8'h7f, 24'h0}, 1'b0, 24'd1};
        rows[1]  = '{1'b0, 15'd0, '{32'h0000_0000, 1'b1, 7'd127, 16'd0}, 1'b1, 3,
                     {8'h00, 8'h7f, 8'h00, 32'h0}, 1'b0, 24'd2};
        rows[2]  = '{1'b0, 15'd0, '{32'h0001_0000, 1'b0, 7'd0, 16'hffff}, 1'b1, 4,
                     {8'h60, 8'h80, 8'h00, 8'h7f, 24'h0}, 1'b0, 24'd2};
        rows[3]  = '{1'b0, 15'd0, '{32'h0000_8000, 1'b0, 7'd1, 16'd1}, 1'b1, 1,
                     56'h0, 1'b1, 24'd2};
        // A backward step small enough to round to a zero delta.
        rows[4]  = '{1'b0, 15'd0, '{32'h0000_fed4, 1'b0, 7'd5, 16'd16384}, 1'b0, 0,
                     56'h0, 1'b0, 24'd0};
        rows[5]  = '{1'b0, 15'd0, '{32'hffff_ffff, 1'b1, 7'd64, 16'd100}, 1'b0, 0,
                     56'h0, 1'b0, 24'd0};
        // Largest divisions: backward jump rejected, then a zero delta.
        rows[6]  = '{1'b1, 15'd32767, '{32'h0000_0000, 1'b1, 7'd9, 16'd500}, 1'b1, 1,
                     56'h0, 1'b1, 24'd3};
        rows[7]  = '{1'b0, 15'd0, '{32'hffff_ffff, 1'b0, 7'd77, 16'd32767}, 1'b0, 0,
                     56'h0, 1'b0, 24'd0};
        // Zero divisions: every delta is zero, even going backward.
        rows[8]  = '{1'b1, 15'd0, '{32'h0000_0000, 1'b0, 7'd33, 16'd32767}, 1'b0, 0,
                     56'h0, 1'b0, 24'd0};
        // Four-byte delta just under the limit, then one just over it.
        rows[9]  = '{1'b1, 15'd32767, '{32'h2000_0000, 1'b1, 7'd100, 16'd20000}, 1'b0, 0,
                     56'h0, 1'b0, 24'd0};
        rows[10] = '{1'b0, 15'd0, '{32'h4001_0000, 1'b1, 7'd2, 16'd3}, 1'b1, 1,
                     56'h0, 1'b1, 24'd4};
        // One tick per quarter note: rounding at the half-tick boundary.
        rows[11] = '{1'b1, 15'd1, '{32'h2000_0001, 1'b1, 7'd10, 16'd1000}, 1'b0, 0,
                     56'h0, 1'b0, 24'd0};
        rows[12] = '{1'b0, 15'd0, '{32'h2000_8001, 1'b0, 7'd11, 16'd2000}, 1'b0, 0,
                     56'h0, 1'b0, 24'd0};
        rows[13] = '{1'b0, 15'd0, '{32'h2001_0000, 1'b0, 7'd12, 16'd3000}, 1'b0, 0,
                     56'h0, 1'b0, 24'd0};
        // Two- and three-byte deltas at their lower edges.
        rows[14] = '{1'b0, 15'd0, '{32'h2081_0000, 1'b1, 7'd13, 16'd4000}, 1'b0, 0,
                     56'h0, 1'b0, 24'd0};
        rows[15] = '{1'b0, 15'd0, '{32'h6081_0000, 1'b1, 7'd14, 16'd5000}, 1'b0, 0,
                     56'h0, 1'b0, 24'd0};
        rows[16] = '{1'b1, 15'd96, '{32'h6082_0000, 1'b0, 7'd127, 16'd32769}, 1'b0, 0,
                     56'h0, 1'b0, 24'd0};

        phase_div[0] = DIVISIONS_RESET;
        phase_div[1] = 15'd1;
        phase_div[2] = 15'd32767;
        phase_div[3] = 15'($urandom_range(2, 32766));
        phase_div[4] = 15'd480;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table.
        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            if (rows[r].write_div)
                set_divisions(rows[r].div_value);
            if (rows[r].typed)
                for (int i = 0; i < rows[r].typed_len; i++)
                    typed_results.push_back('{rows[r].typed_bytes[55 - 8 * i -: 8],
                                              i == rows[r].typed_len - 1,
                                              rows[r].typed_err, rows[r].typed_count});
            offer_event(rows[r].ev);
        end

        // Random phases: mostly forward steps of every size, some backward and wild times.
        item_no = 0;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            set_divisions(phase_div[phase]);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                ev.note_on = 1'($urandom_range(0, 1));
                ev.pitch   = 7'($urandom_range(0, 127));
                ev.volume  = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 32768))
                                                        : 16'($urandom());
                pick = $urandom_range(0, 99);
                if (pick < 40)
                    ev.event_time = last_time + $urandom_range(0, 32'h3_ffff);
                else if (pick < 60)
                    ev.event_time = last_time + $urandom_range(0, 32'hff_ffff);
                else if (pick < 70)
                    ev.event_time = last_time + ($urandom() >> 1);
                else if (pick < 80)
                    ev.event_time = last_time - $urandom_range(0, 32'h1_ffff);
                else if (pick < 90)
                    ev.event_time = $urandom();
                else
                    ev.event_time = last_time;
                gaps_on = !(item_no >= 100 && item_no < 160);
                offer_event(ev);
                item_no++;
            end
        end

        // Drain.
        push <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Encoded %0d note events into %0d checked bytes, %0d with rejected deltas,",
                 events_accepted, bytes_checked, rejected_deltas);
        $display("across %0d divisions writes including zero, one and the maximum.",
                 div_writes);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: midi_note_event_encoder.f
+incdir+rtl
rtl/mnee_pkg.sv
rtl/mnee_front.sv
rtl/mnee_queue.sv
rtl/mnee_back.sv
rtl/midi_note_event_encoder.sv
dv/tb_midi_note_event_encoder.sv
